// ===== rtl/core/dvc_pkg.sv =====
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared types and constants for the dotted version comparator: character
// codes, parse phases, result codes and the snapshot control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dvc_pkg;

    localparam int PART_COUNT_DEF = 4;
    localparam int PART_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_V_LOWER = 8'h76;
    localparam logic [7:0] CHAR_V_UPPER = 8'h56;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic signed [1:0] ORDER_OLDER = 2'sb11;
    localparam logic signed [1:0] ORDER_EQUAL = 2'sb00;
    localparam logic signed [1:0] ORDER_NEWER = 2'sb01;

    typedef enum logic [1:0] {
        PHASE_PREFIX = 2'd0,
        PHASE_PARTS  = 2'd1,
        PHASE_TRAIL  = 2'd2
    } phase_t;

    // Prerelease flags of the two strings that travel with a compare request
    typedef struct packed {
        logic first_pre;
        logic second_pre;
    } snap_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dvc_parser.sv =====
// ----------------------------------------------------------------------------
// dvc_parser
// Per-character version parser. Updates the running part values, stores the
// first string at its end, and issues a compare request at the end of the
// second string.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_parser #(
    parameter int PART_COUNT = dvc_pkg::PART_COUNT_DEF,
    parameter int PART_WIDTH = dvc_pkg::PART_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_char,
    input  wire logic                  in_present,
    input  wire logic                  in_which,
    input  wire logic                  in_last,
    output logic                       in_ready,
    output logic                       snap_valid,
    input  wire logic                  snap_ready,
    output dvc_pkg::snap_ctl_t         snap_ctl,
    output logic [PART_WIDTH-1:0]      snap_first [PART_COUNT],
    output logic [PART_WIDTH-1:0]      snap_second [PART_COUNT]
);
    import dvc_pkg::*;

    localparam int IDX_W  = $clog2(PART_COUNT + 1);
    localparam int WIDE_W = PART_WIDTH + 4;

    phase_t                phase_reg, phase_next, phase_eff;
    logic [IDX_W-1:0]      idx_reg, idx_upd, idx_next, idx_eff;
    logic                  seen_reg, seen_upd, seen_next, seen_eff;
    logic                  pre_reg, pre_upd, pre_next;
    logic [PART_WIDTH-1:0] parts_reg [PART_COUNT];
    logic [PART_WIDTH-1:0] parts_upd [PART_COUNT];
    logic [PART_WIDTH-1:0] parts_next [PART_COUNT];
    logic [PART_WIDTH-1:0] first_parts_reg [PART_COUNT];
    logic [PART_WIDTH-1:0] first_parts_next [PART_COUNT];
    logic                  first_pre_reg, first_pre_next;
    logic                  snap_valid_reg;
    snap_ctl_t             snap_ctl_reg;
    logic [PART_WIDTH-1:0] snap_first_reg [PART_COUNT];
    logic [PART_WIDTH-1:0] snap_second_reg [PART_COUNT];

    logic                  take, end_first, end_second;
    logic                  is_digit, is_dot, is_space, is_skip, is_mark;
    logic                  idx_full, idx_at_last;
    logic [PART_WIDTH-1:0] cur_part, new_part;
    logic [WIDE_W-1:0]     wide;
    logic [3:0]            digit;

    assign end_second = in_valid && in_last && in_which;
    assign in_ready   = !end_second || !snap_valid_reg || snap_ready;
    assign take       = in_valid && in_ready;
    assign end_first  = take && in_last && !in_which;

    assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    assign is_dot   = (in_char == CHAR_DOT);
    assign is_space = (in_char == CHAR_SPACE);
    assign is_skip  = (in_char == CHAR_V_LOWER) || (in_char == CHAR_V_UPPER) || is_space;
    assign is_mark  = !is_dot && !is_space;
    assign digit    = in_char[3:0];

    // Leaving the prefix phase starts the first part fresh
    assign phase_eff = (phase_reg == PHASE_PREFIX && !is_skip) ? PHASE_PARTS : phase_reg;
    assign idx_eff   = (phase_reg == PHASE_PREFIX) ? '0 : idx_reg;
    assign seen_eff  = (phase_reg == PHASE_PREFIX) ? 1'b0 : seen_reg;

    assign idx_full    = idx_eff >= IDX_W'(PART_COUNT);
    assign idx_at_last = idx_eff >= IDX_W'(PART_COUNT - 1);

    always_comb begin
        cur_part = '0;
        for (int i = 0; i < PART_COUNT; i++) begin
            if (IDX_W'(i) == idx_eff) begin
                cur_part = parts_reg[i];
            end
        end
    end

    // Times ten plus digit, saturating at the part maximum
    assign wide     = ({4'b0, cur_part} << 3) + ({4'b0, cur_part} << 1)
                    + {{(WIDE_W-4){1'b0}}, digit};
    assign new_part = (|wide[WIDE_W-1 -: 4]) ? {PART_WIDTH{1'b1}} : wide[PART_WIDTH-1:0];

    // Next parse phase
    always_comb begin
        phase_next = phase_reg;
        if (take && in_present) begin
            case (phase_eff)
                PHASE_PREFIX: phase_next = PHASE_PREFIX;
                PHASE_PARTS: begin
                    if (is_digit) begin
                        phase_next = idx_full ? PHASE_TRAIL : PHASE_PARTS;
                    end else if (is_dot && seen_eff) begin
                        phase_next = idx_at_last ? PHASE_TRAIL : PHASE_PARTS;
                    end else begin
                        phase_next = PHASE_TRAIL;
                    end
                end
                PHASE_TRAIL: phase_next = PHASE_TRAIL;
                default:     phase_next = PHASE_PREFIX;
            endcase
        end
        if (take && in_last) begin
            phase_next = PHASE_PREFIX;
        end
    end

    // Part values, index and flags for this character
    always_comb begin
        parts_upd = parts_reg;
        idx_upd   = idx_reg;
        seen_upd  = seen_reg;
        pre_upd   = pre_reg;
        if (take && in_present) begin
            case (phase_eff)
                PHASE_PARTS: begin
                    idx_upd  = idx_eff;
                    seen_upd = seen_eff;
                    if (is_digit) begin
                        if (!idx_full) begin
                            for (int i = 0; i < PART_COUNT; i++) begin
                                if (IDX_W'(i) == idx_eff) begin
                                    parts_upd[i] = new_part;
                                end
                            end
                            seen_upd = 1'b1;
                        end
                    end else if (is_dot && seen_eff) begin
                        idx_upd  = idx_eff + IDX_W'(1);
                        seen_upd = 1'b0;
                    end else if (is_mark) begin
                        pre_upd = 1'b1;
                    end
                end
                PHASE_TRAIL: begin
                    if (is_mark) begin
                        pre_upd = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Restart after any string end; store or clear the first string
    always_comb begin
        parts_next       = parts_upd;
        idx_next         = idx_upd;
        seen_next        = seen_upd;
        pre_next         = pre_upd;
        first_parts_next = first_parts_reg;
        first_pre_next   = first_pre_reg;
        if (take && in_last) begin
            for (int i = 0; i < PART_COUNT; i++) begin
                parts_next[i] = '0;
            end
            idx_next  = '0;
            seen_next = 1'b0;
            pre_next  = 1'b0;
            if (end_first) begin
                first_parts_next = parts_upd;
                first_pre_next   = pre_upd;
            end else begin
                for (int i = 0; i < PART_COUNT; i++) begin
                    first_parts_next[i] = '0;
                end
                first_pre_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_PREFIX;
            idx_reg       <= '0;
            seen_reg      <= 1'b0;
            pre_reg       <= 1'b0;
            first_pre_reg <= 1'b0;
            for (int i = 0; i < PART_COUNT; i++) begin
                parts_reg[i]       <= '0;
                first_parts_reg[i] <= '0;
            end
            snap_valid_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            seen_reg        <= seen_next;
            pre_reg         <= pre_next;
            first_pre_reg   <= first_pre_next;
            parts_reg       <= parts_next;
            first_parts_reg <= first_parts_next;
            if (take && end_second) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_ready) begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && end_second) begin
            snap_first_reg  <= first_parts_reg;
            snap_second_reg <= parts_upd;
            snap_ctl_reg    <= '{first_pre: first_pre_reg, second_pre: pre_upd};
        end
    end

    assign snap_valid  = snap_valid_reg;
    assign snap_ctl    = snap_ctl_reg;
    assign snap_first  = snap_first_reg;
    assign snap_second = snap_second_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dvc_compare.sv =====
// ----------------------------------------------------------------------------
// dvc_compare
// Compares the two captured versions part by part, lowest part first, with a
// prerelease ranking below the plain version, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_compare #(
    parameter int PART_COUNT = dvc_pkg::PART_COUNT_DEF,
    parameter int PART_WIDTH = dvc_pkg::PART_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  snap_valid,
    output logic                       snap_ready,
    input  wire dvc_pkg::snap_ctl_t    snap_ctl,
    input  wire logic [PART_WIDTH-1:0] snap_first [PART_COUNT],
    input  wire logic [PART_WIDTH-1:0] snap_second [PART_COUNT],
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [1:0]          m_order
);
    import dvc_pkg::*;

    logic               m_valid_reg;
    logic signed [1:0]  m_order_reg, order_next;

    always_comb begin
        if (snap_ctl.first_pre != snap_ctl.second_pre) begin
            order_next = snap_ctl.first_pre ? ORDER_OLDER : ORDER_NEWER;
        end else begin
            order_next = ORDER_EQUAL;
        end
        // Walk from the last part down so the first differing part wins
        for (int i = PART_COUNT - 1; i >= 0; i--) begin
            if (snap_first[i] < snap_second[i]) begin
                order_next = ORDER_OLDER;
            end else if (snap_first[i] > snap_second[i]) begin
                order_next = ORDER_NEWER;
            end
        end
    end

    assign snap_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            m_order_reg <= order_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_order = m_order_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dotted_version_compare.sv =====
// ----------------------------------------------------------------------------
// dotted_version_compare
// Streams two version strings one character per request and returns the
// ordering of the first against the second at the end of the second string.
//
//   channel | direction | ports                                           | request
//   s_      | in        | s_char_byte s_byte_present s_which_string        | one char
//           |           | s_end_of_string                                  |
//   m_      | out       | m_order (-1 older, 0 equal, 1 newer)             | one result
//
// One request per cycle is taken while s_ready is high. A request lands in the
// input register when accepted and the parser consumes it from there; at the end
// of the second string the parser registers a compare request, and the compare
// stage registers the result that drives m_order and m_valid.
// Reset is synchronous on aresetn and needs no clearing pass.
// With a result held on m_order and a second compare waiting, a request that
// ends a further second string holds in the input register and s_ready drops
// for every request until m_ready frees the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dotted_version_compare #(
    parameter int PART_COUNT = dvc_pkg::PART_COUNT_DEF,
    parameter int PART_WIDTH = dvc_pkg::PART_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_char_byte,
    input  wire logic             s_byte_present,
    input  wire logic             s_which_string,
    input  wire logic             s_end_of_string,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic signed [1:0]     m_order
);
    import dvc_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_present_reg, in_which_reg, in_last_reg;
    logic                  in_ready;
    logic                  snap_valid, snap_ready;
    snap_ctl_t             snap_ctl;
    logic [PART_WIDTH-1:0] snap_first [PART_COUNT];
    logic [PART_WIDTH-1:0] snap_second [PART_COUNT];

    assign s_ready = !in_valid_reg || in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg    <= s_char_byte;
            in_present_reg <= s_byte_present;
            in_which_reg   <= s_which_string;
            in_last_reg    <= s_end_of_string;
        end
    end

    dvc_parser #(
        .PART_COUNT (PART_COUNT),
        .PART_WIDTH (PART_WIDTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid_reg),
        .in_char     (in_char_reg),
        .in_present  (in_present_reg),
        .in_which    (in_which_reg),
        .in_last     (in_last_reg),
        .in_ready    (in_ready),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap_ctl    (snap_ctl),
        .snap_first  (snap_first),
        .snap_second (snap_second)
    );

    dvc_compare #(
        .PART_COUNT (PART_COUNT),
        .PART_WIDTH (PART_WIDTH)
    ) u_compare (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap_ctl    (snap_ctl),
        .snap_first  (snap_first),
        .snap_second (snap_second),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_order     (m_order)
    );

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_end_issues_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_ready && in_last_reg && in_which_reg) |=> snap_valid)
        else $error("end of second string did not raise a compare request");

    a_result_from_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(snap_valid))
        else $error("result appeared without a compare request");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for dotted_version_compare. Streams version strings as one
// character request per handshake, predicts each ordering in-bench and checks
// every m_order against the oldest pending prediction. A short directed table
// runs first, then random well-formed version pairs mixed with noise, across
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dvc_pkg::*;

    localparam int NPARTS      = PART_COUNT_DEF;
    localparam int PW          = PART_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 240;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0]        ch;
        logic              present;
        logic              which;
        logic              eos;
        logic              pinned;
        logic signed [1:0] pinned_order;
    } char_req_t;

    // Directed requests; pinned rows carry an ordering readable at a glance
    localparam char_req_t DIRECTED_REQS [24] = '{
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ORDER_EQUAL},  // empty first
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, ORDER_EQUAL},  // empty second
        '{"V",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},  // V9999999999 saturates
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},
        '{"9",   1'b1, 1'b0, 1'b1, 1'b0, ORDER_EQUAL},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, ORDER_NEWER},  // empty second
        '{"0",   1'b1, 1'b0, 1'b0, 1'b0, ORDER_EQUAL},  // first "0" + 0xFF
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, ORDER_EQUAL},
        '{"0",   1'b1, 1'b1, 1'b1, 1'b1, ORDER_OLDER},  // prerelease ranks lower
        '{".",   1'b1, 1'b1, 1'b0, 1'b0, ORDER_EQUAL},  // which ignored mid-string
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, ORDER_EQUAL},
        '{" ",   1'b1, 1'b1, 1'b0, 1'b0, ORDER_EQUAL},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, ORDER_EQUAL},
        '{"3",   1'b1, 1'b1, 1'b0, 1'b0, ORDER_EQUAL},
        '{".",   1'b1, 1'b0, 1'b1, 1'b0, ORDER_EQUAL},
        '{"3",   1'b1, 1'b1, 1'b1, 1'b0, ORDER_EQUAL}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_char_byte = 8'h00;
    logic              s_byte_present = 1'b0;
    logic              s_which_string = 1'b0;
    logic              s_end_of_string = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [1:0] m_order;

    dotted_version_compare i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_byte     (s_char_byte),
        .s_byte_present  (s_byte_present),
        .s_which_string  (s_which_string),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_order         (m_order)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    char_req_t         req_q [$];
    logic signed [1:0] order_q [$];
    logic [7:0]        ver_buf [$];
    logic [7:0]        first_buf [$];
    char_req_t         cur_req;
    bit                req_taken = 1'b0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_left = 0;
    int                items_sent = 0;
    int                errors = 0;
    int                idle_cycles = 0;

    // In-bench parser state
    logic [PW-1:0]     stored_parts [NPARTS];
    bit                stored_pre;
    logic [PW-1:0]     work_parts [NPARTS];
    bit                work_pre;
    phase_t            work_phase;
    int                work_idx;
    bit                work_digit;

    function void restart_work();
        for (int i = 0; i < NPARTS; i++) work_parts[i] = '0;
        work_pre   = 1'b0;
        work_phase = PHASE_PREFIX;
        work_idx   = 0;
        work_digit = 1'b0;
    endfunction

    function void clear_stored();
        for (int i = 0; i < NPARTS; i++) stored_parts[i] = '0;
        stored_pre = 1'b0;
    endfunction

    function void parse_char(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] mx;
        mx = (64'd1 << PW) - 64'd1;
        if (work_phase == PHASE_PREFIX) begin
            if (c == CHAR_V_LOWER || c == CHAR_V_UPPER || c == CHAR_SPACE) return;
            work_phase = PHASE_PARTS;
            work_idx   = 0;
            work_digit = 1'b0;
        end
        if (work_phase == PHASE_PARTS) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (work_idx >= NPARTS) begin
                    work_phase = PHASE_TRAIL;
                    return;
                end
                d = 64'(c - CHAR_ZERO);
                v = 64'(work_parts[work_idx]);
                // saturate instead of wrapping
                work_parts[work_idx] = (v > (mx - d) / 64'd10) ? mx[PW-1:0]
                                                               : PW'(v * 64'd10 + d);
                work_digit = 1'b1;
                return;
            end
            if (c == CHAR_DOT && work_digit) begin
                work_idx++;
                work_digit = 1'b0;
                if (work_idx >= NPARTS) work_phase = PHASE_TRAIL;
                return;
            end
            work_phase = PHASE_TRAIL;
        end
        if (c != CHAR_DOT && c != CHAR_SPACE) work_pre = 1'b1;
    endfunction

    function logic signed [1:0] rank_versions();
        for (int i = 0; i < NPARTS; i++) begin
            if (stored_parts[i] < work_parts[i]) return ORDER_OLDER;
            if (stored_parts[i] > work_parts[i]) return ORDER_NEWER;
        end
        if (stored_pre != work_pre) return stored_pre ? ORDER_OLDER : ORDER_NEWER;
        return ORDER_EQUAL;
    endfunction

    // Advance the parser by one request; returns 1 when an ordering comes out
    function bit predict_order(input char_req_t r, output logic signed [1:0] ord);
        ord = ORDER_EQUAL;
        if (r.present) parse_char(r.ch);
        if (!r.eos) return 1'b0;
        if (!r.which) begin
            for (int i = 0; i < NPARTS; i++) stored_parts[i] = work_parts[i];
            stored_pre = work_pre;
            restart_work();
            return 1'b0;
        end
        ord = rank_versions();
        clear_stored();
        restart_work();
        return 1'b1;
    endfunction

    initial begin
        clear_stored();
        restart_work();
    end

    // Sender: change inputs on the falling edge
    always @(negedge aclk) begin
        if (!s_valid || req_taken) begin
            if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = req_q.pop_front();
                s_char_byte     <= cur_req.ch;
                s_byte_present  <= cur_req.present;
                s_which_string  <= cur_req.which;
                s_end_of_string <= cur_req.eos;
                s_valid         <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    logic signed [1:0] pred_ord;
    logic signed [1:0] want_ord;
    bit                s_fire;
    bit                m_fire;

    always @(posedge aclk) begin
        if (aresetn) begin
            s_fire = s_valid && s_ready;
            m_fire = m_valid && m_ready;
            if (m_fire) begin
                if (order_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got order %0d",
                             $time, m_order);
                end else begin
                    want_ord = order_q.pop_front();
                    if (m_order !== want_ord) begin
                        errors++;
                        $display("%0t: order mismatch, expected %0d, got %0d",
                                 $time, want_ord, m_order);
                    end
                end
            end
            if (s_fire) begin
                req_taken = 1'b1;
                if (predict_order(cur_req, pred_ord))
                    order_q.push_back(cur_req.pinned ? cur_req.pinned_order : pred_ord);
            end
            if (s_fire || m_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles, %0d results pending",
                             $time, idle_cycles, order_q.size());
                    $display("tb_top NOT OK");
                    $finish;
                end
            end
        end
    end

    task push_req(input logic [7:0] ch, input bit present, input bit which, input bit eos);
        req_q.push_back('{ch, present, which, eos, 1'b0, ORDER_EQUAL});
        items_sent++;
    endtask

    function logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                                    : $urandom_range(0, 9));
    endfunction

    task gen_version();
        int np;
        int len;
        ver_buf.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: ver_buf.push_back(CHAR_V_LOWER);
                    1: ver_buf.push_back(CHAR_V_UPPER);
                    default: ver_buf.push_back(CHAR_SPACE);
                endcase
            end
        end
        np = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
        for (int p = 0; p < np; p++) begin
            if (p > 0) ver_buf.push_back(CHAR_DOT);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 2);
            repeat (len) ver_buf.push_back(rand_digit());
        end
        if ($urandom_range(0, 9) == 0) ver_buf.push_back(CHAR_DOT);
        case ($urandom_range(0, 5))
            0: begin
                ver_buf.push_back("-");
                ver_buf.push_back("r");
                ver_buf.push_back("c");
            end
            1: ver_buf.push_back(8'($urandom_range(0, 255)));
            2: begin
                ver_buf.push_back(CHAR_SPACE);
                ver_buf.push_back("b");
            end
            default: ;
        endcase
    endtask

    task mutate_version();
        int pos;
        if (ver_buf.size() > 0 && $urandom_range(0, 1)) begin
            pos = $urandom_range(0, ver_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: ver_buf[pos] = rand_digit();
                1: ver_buf[pos] = CHAR_DOT;
                2: ver_buf[pos] = 8'($urandom_range(0, 255));
                default: ver_buf.delete(pos);
            endcase
        end else begin
            ver_buf.push_back(rand_digit());
        end
    endtask

    // Send ver_buf as one string; end either on the last byte or on a bare marker
    task push_string(input bit which);
        bit bare_end;
        bare_end = (ver_buf.size() == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < ver_buf.size(); i++) begin
            if (!bare_end && i == ver_buf.size() - 1) begin
                push_req(ver_buf[i], 1'b1, which, 1'b1);
            end else begin
                push_req(ver_buf[i], 1'b1, 1'($urandom_range(0, 1)), 1'b0);
                if ($urandom_range(0, 15) == 0)
                    push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
            end
        end
        if (bare_end) push_req(8'($urandom_range(0, 255)), 1'b0, which, 1'b1);
    endtask

    task gen_round();
        int k;
        k = $urandom_range(0, 99);
        if (k < 12) begin
            repeat ($urandom_range(1, 6))
                push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            first_buf.delete();
            if (k >= 20) begin
                if (k < 26) begin
                    // a first string that gets replaced
                    gen_version();
                    push_string(1'b0);
                end
                gen_version();
                first_buf = ver_buf;
                push_string(1'b0);
            end
            if ($urandom_range(0, 1)) begin
                ver_buf = first_buf;
                if ($urandom_range(0, 2) != 0) mutate_version();
            end else begin
                gen_version();
            end
            push_string(1'b1);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 0) begin
                foreach (DIRECTED_REQS[i]) req_q.push_back(DIRECTED_REQS[i]);
            end
            while (items_sent < (ph + 1) * PHASE_ITEMS) gen_round();
            // hold the receiver off while requests keep coming, to fill the block
            if (ph == 0) hold_left = HOLD_CYCLES;
            while (req_q.size() != 0 || s_valid) @(posedge aclk);
            while (order_q.size() != 0) @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
